FILE: hdl/assert_macros.svh
// assertion helpers, clocked on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define MRI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication
`define MRI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mri_pkg.sv
package mri_pkg;

  // number formats
  localparam int unsigned POINT_FRAC_BITS = 30;
  localparam int unsigned COUNT_BITS      = 32;

  localparam int unsigned PT_W       = 32;
  localparam int unsigned WID_W      = 31;
  localparam int unsigned CFG_CNT_W  = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned AREA_W     = 48;
  localparam int unsigned CNT_W      = (COUNT_BITS < CFG_CNT_W) ? COUNT_BITS : CFG_CNT_W;

  // doubled sample point, cap at 2^X_W where the curve is zero
  localparam int unsigned X_W  = POINT_FRAC_BITS + 18;
  localparam int unsigned XR_W = X_W + 1;

  // shared multiplier: half-width slices, four passes per product
  localparam int unsigned MUL_W     = (X_W + 1) / 2;
  localparam int unsigned OP_W      = 2 * MUL_W;
  localparam int unsigned PP_W      = 2 * MUL_W;
  localparam int unsigned PROD_W    = 4 * MUL_W;
  localparam int unsigned MUL_STEPS = 4;

  // x^2 in Q.28 and curve value in Q.31
  localparam int unsigned SQ_SHIFT   = 2 * POINT_FRAC_BITS - 26;
  localparam int unsigned Q_W        = 62;
  localparam int unsigned F_W        = 34;
  localparam int unsigned DVSR_W     = 63;
  localparam int unsigned REM_W      = DVSR_W + 1;
  localparam int unsigned DIV_STEPS  = F_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);
  localparam logic [DVSR_W-1:0] DVSR_BASE = DVSR_W'(64'd1 << 28);
  localparam logic [DVSR_W-1:0] REM_INIT  = DVSR_W'(64'd1 << 27);

  // rectangle term in Q.40
  localparam int unsigned TERM_SHIFT = POINT_FRAC_BITS - 9;
  localparam int unsigned TERM_W     = 64 - TERM_SHIFT;
  localparam int unsigned SUM_W      = ((TERM_W > AREA_W) ? TERM_W : AREA_W) + 1;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  // register reset values and indexes
  localparam logic [WID_W-1:0]     RECT_WIDTH_RST = WID_W'(1048576);
  localparam logic [CFG_CNT_W-1:0] RECT_COUNT_RST = CFG_CNT_W'(1024);
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_COUNT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_SQ,
    S_DIV_INIT,
    S_DIV,
    S_MUL_TM,
    S_ACC,
    S_FINISH
  } mri_state_e;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic       mul_sq;
    logic [1:0] mul_sel;
    logic       prod_en;
    logic       prod_clr;
    logic       div_init;
    logic       div_step;
    logic       acc_upd;
    logic       out_load;
  } mri_cmd_t;

  typedef struct packed {
    logic neg;
    logic single;
    logic cnt_done;
    logic x_capped;
    logic term_zero;
    logic sum_ovf;
  } mri_stat_t;

endpackage

FILE: hdl/midpoint_rule_integrator.sv
// Midpoint-rule integrator of 4/(1+x^2) over a span given per input word.
// Input channel: in_valid_i/in_ready_o with span_start_i and span_stop_i,
// unsigned Q2.30. Output channel: out_valid_o/out_ready_i with area_o
// (unsigned Q8.40, clipped) and saturated_o. One result word per input word.
// Configuration: cfg_we_i writes cfg_data_i to rect_width (index 0) or
// rect_count (index 1) at the clock edge. The user must write only while the
// block is idle; the block does not enforce this. A job loads the span, then
// checks before each rectangle, stopping on the rectangle count or on a
// capped sample point; up to rect_count rectangles, a non-negative span
// narrower than rect_width evaluates exactly one and a negative span none.
// Each rectangle uses the 34-step restoring divider and two four-pass
// slice multiplies on one shared multiplier. The loop ends early once a
// term is zero or the sum clips. Jobs run one at a time.
// The result sits in an output register, so the next word is accepted while
// it waits; a finished job then holds until the receiver takes the old word.
// Reset (rst_ni low, asynchronous) returns to idle, drops any pending result
// and restores rect_width = 2^20 and rect_count = 1024.
module midpoint_rule_integrator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mri_pkg::PT_W-1:0]          span_start_i,
  input  logic [mri_pkg::PT_W-1:0]          span_stop_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mri_pkg::AREA_W-1:0]        area_o,
  output logic                              saturated_o,
  input  logic                              cfg_we_i,
  input  logic [mri_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mri_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import mri_pkg::*;

  logic [WID_W-1:0]     rect_width_q;
  logic [CFG_CNT_W-1:0] rect_count_q;
  mri_cmd_t             cmd;
  mri_stat_t            stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_width_q <= RECT_WIDTH_RST;
      rect_count_q <= RECT_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RECT_WIDTH: rect_width_q <= cfg_data_i[WID_W-1:0];
        CFG_RECT_COUNT: rect_count_q <= cfg_data_i[CFG_CNT_W-1:0];
        default:        rect_width_q <= rect_width_q;
      endcase
    end
  end

  // sequencer
  mri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic
  mri_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .span_start_i (span_start_i),
    .span_stop_i  (span_stop_i),
    .rect_width_i (rect_width_q),
    .rect_count_i (rect_count_q[CNT_W-1:0]),
    .area_o       (area_o),
    .saturated_o  (saturated_o)
  );

endmodule

FILE: hdl/mri_ctrl.sv
`include "assert_macros.svh"

module mri_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mri_pkg::mri_stat_t  stat_i,
  output mri_pkg::mri_cmd_t   cmd_o
);
  import mri_pkg::*;

  mri_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  // state, step counter and output word flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.neg || stat_i.x_capped || (!stat_i.single && stat_i.cnt_done)) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_MUL_SQ;
          step_d  = '0;
        end
      end
      S_MUL_SQ, S_MUL_TM: begin
        // passes issue slice products, each accumulated in the cycle after its pass
        if (step_q < STEP_W'(MUL_STEPS)) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sq  = (state_q == S_MUL_SQ);
          cmd_o.mul_sel = step_q[1:0];
        end
        if (step_q != '0) begin
          cmd_o.prod_en  = 1'b1;
          cmd_o.prod_clr = (step_q == STEP_W'(1));
        end
        if (step_q == STEP_W'(MUL_STEPS)) begin
          step_d  = '0;
          state_d = (state_q == S_MUL_SQ) ? S_DIV_INIT : S_ACC;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          step_d  = '0;
          state_d = S_MUL_TM;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_ACC: begin
        cmd_o.acc_upd = 1'b1;
        if (stat_i.single || stat_i.term_zero || stat_i.sum_ovf) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `MRI_ASSERT_IMP(a_no_overwrite, cmd_o.out_load, !out_valid_q || out_ready_i, "pending result overwritten")
  `MRI_ASSERT_NEXT(a_load_shows, cmd_o.out_load, out_valid_o, "loaded result not offered")
  `MRI_ASSERT_IMP(a_div_bound, state_q == S_DIV, step_q < STEP_W'(DIV_STEPS), "divider overran")

endmodule

FILE: hdl/mri_dp.sv
`include "assert_macros.svh"

module mri_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mri_pkg::mri_cmd_t             cmd_i,
  output mri_pkg::mri_stat_t            stat_o,
  input  logic [mri_pkg::PT_W-1:0]      span_start_i,
  input  logic [mri_pkg::PT_W-1:0]      span_stop_i,
  input  logic [mri_pkg::WID_W-1:0]     rect_width_i,
  input  logic [mri_pkg::CNT_W-1:0]     rect_count_i,
  output logic [mri_pkg::AREA_W-1:0]    area_o,
  output logic                          saturated_o
);
  import mri_pkg::*;

  logic [XR_W-1:0]   x_q;
  logic [WID_W-1:0]  mop_q;
  logic              neg_q, single_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [AREA_W-1:0] acc_q;
  logic              sat_q;
  logic [PP_W-1:0]   pp_q;
  logic [1:0]        pp_sel_q;
  logic [PROD_W-1:0] prod_q;
  logic [DVSR_W-1:0] dvsr_q, rem_q;
  logic [F_W-1:0]    quo_q;
  logic [AREA_W-1:0] area_q;
  logic              saturated_q;

  // job set-up: span test and first sample point
  logic [PT_W:0]     diff;
  logic              neg, single;
  logic [XR_W-1:0]   x_init;
  assign diff   = {1'b0, span_stop_i} - {1'b0, span_start_i};
  assign neg    = diff[PT_W];
  assign single = neg || (diff[PT_W-1:0] < PT_W'(rect_width_i));
  assign x_init = single ? (XR_W'(span_start_i) + XR_W'(span_stop_i))
                         : ((XR_W'(span_start_i) << 1) + XR_W'(rect_width_i));

  // slice multiplier operands
  logic [OP_W-1:0]  opa, opb;
  logic [MUL_W-1:0] a_half, b_half;
  assign opa    = cmd_i.mul_sq ? OP_W'(x_q[X_W-1:0]) : OP_W'(quo_q);
  assign opb    = cmd_i.mul_sq ? OP_W'(x_q[X_W-1:0]) : OP_W'(mop_q);
  assign a_half = cmd_i.mul_sel[0] ? opa[OP_W-1:MUL_W] : opa[MUL_W-1:0];
  assign b_half = cmd_i.mul_sel[1] ? opb[OP_W-1:MUL_W] : opb[MUL_W-1:0];

  // slice product aligned for accumulation
  logic [PROD_W-1:0] pp_sh;
  always_comb begin
    case (pp_sel_q)
      2'b00:   pp_sh = PROD_W'(pp_q);
      2'b11:   pp_sh = PROD_W'(pp_q) << (2 * MUL_W);
      default: pp_sh = PROD_W'(pp_q) << MUL_W;
    endcase
  end

  // restoring divide step
  logic [REM_W-1:0] rem_sh, rem_sub;
  logic             fits;
  assign rem_sh  = {rem_q, 1'b0};
  assign fits    = rem_sh >= REM_W'(dvsr_q);
  assign rem_sub = rem_sh - REM_W'(dvsr_q);

  // rectangle term and running sum
  logic [TERM_W-1:0] term;
  logic [SUM_W-1:0]  sum;
  logic              ovf;
  assign term = prod_q[TERM_SHIFT +: TERM_W];
  assign sum  = SUM_W'(acc_q) + SUM_W'(term);
  assign ovf  = sum > SUM_W'(AREA_MAX);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q      <= x_init;
      mop_q    <= single ? diff[WID_W-1:0] : rect_width_i;
      neg_q    <= neg;
      single_q <= single;
      cnt_q    <= '0;
      acc_q    <= '0;
      sat_q    <= 1'b0;
    end else if (cmd_i.acc_upd && (term != '0)) begin
      if (ovf) begin
        acc_q <= AREA_MAX;
        sat_q <= 1'b1;
      end else begin
        acc_q <= sum[AREA_W-1:0];
      end
      x_q   <= x_q + (XR_W'(rect_width_i) << 1);
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.mul_en) begin
      pp_q     <= a_half * b_half;
      pp_sel_q <= cmd_i.mul_sel;
    end
    if (cmd_i.prod_en) begin
      prod_q <= (cmd_i.prod_clr ? '0 : prod_q) + pp_sh;
    end
    if (cmd_i.div_init) begin
      dvsr_q <= DVSR_W'(prod_q[SQ_SHIFT +: Q_W]) + DVSR_BASE;
      rem_q  <= REM_INIT;
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? rem_sub[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
      quo_q <= {quo_q[F_W-2:0], fits};
    end
    if (cmd_i.out_load) begin
      area_q      <= acc_q;
      saturated_q <= sat_q;
    end
  end

  // status back to the controller
  assign stat_o.neg       = neg_q;
  assign stat_o.single    = single_q;
  assign stat_o.cnt_done  = (cnt_q == rect_count_i);
  assign stat_o.x_capped  = x_q[X_W];
  assign stat_o.term_zero = (term == '0);
  assign stat_o.sum_ovf   = ovf;

  assign area_o      = area_q;
  assign saturated_o = saturated_q;

  `MRI_ASSERT_IMP(a_rem_below, cmd_i.div_step, rem_q < dvsr_q, "remainder not below divisor")
  `MRI_ASSERT_IMP(a_sq_in_range, cmd_i.mul_en && cmd_i.mul_sq, !x_q[X_W], "square of capped point")

endmodule
